// File: hdl/cpu6502_load_shift_stack_execute_defines.svh
// Assertion macros for the 6502 load/shift/stack execute unit.
// Included by the checker module; depends on nothing else.
`ifndef CPU6502_LOAD_SHIFT_STACK_EXECUTE_DEFINES_SVH
`define CPU6502_LOAD_SHIFT_STACK_EXECUTE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define C6502_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("c6502 check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held
`define C6502_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("c6502 check failed: next-cycle rule");

`endif

// File: hdl/c6502_pkg.sv
// Shared types, constants and helpers for the 6502 execute unit.
// No dependencies.
`default_nettype none

package c6502_pkg;

    // Operation codes carried on the mode field
    typedef enum logic [3:0] {
        MODE_LDA   = 4'd0,
        MODE_LDX   = 4'd1,
        MODE_LDY   = 4'd2,
        MODE_ORA   = 4'd3,
        MODE_LSR_A = 4'd4,
        MODE_LSR_M = 4'd5,
        MODE_ROL_A = 4'd6,
        MODE_ROL_M = 4'd7,
        MODE_ROR_A = 4'd8,
        MODE_ROR_M = 4'd9,
        MODE_PHA   = 4'd10,
        MODE_PHP   = 4'd11,
        MODE_PLA   = 4'd12,
        MODE_PLP   = 4'd13
    } mode_t;

    localparam logic [7:0] SIGN_BIT   = 8'h80;
    localparam logic [7:0] PUSH_BITS  = 8'b0011_0000;
    localparam logic [7:0] CARRY_BIT  = 8'h01;
    localparam logic [8:0] STACK_PAGE = 9'h100;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h24;

    // Architectural registers
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] idx_x;
        logic [7:0] idx_y;
        logic [7:0] sp;
        logic [7:0] flags;
    } arch_t;

    // Per-operation side outputs
    typedef struct packed {
        logic [7:0] write_value;
        logic       write_enable;
        logic [8:0] stack_address;
        logic       uses_stack;
    } side_t;

    // Update N (bit 7) and Z (bit 1) from a result byte
    function automatic logic [7:0] set_nz(input logic [7:0] flags, input logic [7:0] v);
        logic [7:0] f;
        f    = flags;
        f[7] = v[7];
        f[1] = (v == 8'h00);
        return f;
    endfunction

endpackage

`default_nettype wire

// File: hdl/c6502_alu.sv
// Combinational execute logic: one operation against the register file.
// Depends on c6502_pkg.
`default_nettype none

module c6502_alu (
    input  wire logic [3:0]       mode,
    input  wire logic [7:0]       operand,
    input  wire c6502_pkg::arch_t arch_cur,
    output c6502_pkg::arch_t      arch_new,
    output c6502_pkg::side_t      side
);

    logic [7:0] shift_src;
    logic [7:0] shift_res;
    logic       shift_c;
    logic [7:0] shift_flags;
    logic [7:0] sp_inc;

    // Shifter: source is A for the accumulator forms, else the operand word
    always_comb begin
        shift_src = mode[0] ? operand : arch_cur.acc;
        unique case (mode)
            c6502_pkg::MODE_ROL_A, c6502_pkg::MODE_ROL_M: begin
                shift_res = {shift_src[6:0], arch_cur.flags[0]};
                shift_c   = shift_src[7];
            end
            c6502_pkg::MODE_ROR_A, c6502_pkg::MODE_ROR_M: begin
                shift_res = {arch_cur.flags[0], shift_src[7:1]};
                shift_c   = shift_src[0];
            end
            default: begin
                shift_res = {1'b0, shift_src[7:1]};
                shift_c   = shift_src[0];
            end
        endcase
        shift_flags    = c6502_pkg::set_nz(arch_cur.flags, shift_res);
        shift_flags[0] = shift_c;
    end

    assign sp_inc = arch_cur.sp + 8'd1;

    // Operation decode
    always_comb begin
        arch_new           = arch_cur;
        side.write_value   = 8'h00;
        side.write_enable  = 1'b0;
        side.stack_address = c6502_pkg::STACK_PAGE | {1'b0, arch_cur.sp};
        side.uses_stack    = 1'b0;
        unique case (mode)
            c6502_pkg::MODE_LDA: begin
                arch_new.acc   = operand;
                arch_new.flags = c6502_pkg::set_nz(arch_cur.flags, operand);
            end
            c6502_pkg::MODE_LDX: begin
                arch_new.idx_x = operand;
                arch_new.flags = c6502_pkg::set_nz(arch_cur.flags, operand);
            end
            c6502_pkg::MODE_LDY: begin
                arch_new.idx_y = operand;
                arch_new.flags = c6502_pkg::set_nz(arch_cur.flags, operand);
            end
            c6502_pkg::MODE_ORA: begin
                arch_new.acc   = arch_cur.acc | operand;
                arch_new.flags = c6502_pkg::set_nz(arch_cur.flags, arch_cur.acc | operand);
            end
            c6502_pkg::MODE_LSR_A, c6502_pkg::MODE_ROL_A, c6502_pkg::MODE_ROR_A: begin
                arch_new.acc   = shift_res;
                arch_new.flags = shift_flags;
            end
            c6502_pkg::MODE_LSR_M, c6502_pkg::MODE_ROL_M, c6502_pkg::MODE_ROR_M: begin
                arch_new.flags    = shift_flags;
                side.write_value  = shift_res;
                side.write_enable = 1'b1;
            end
            c6502_pkg::MODE_PHA, c6502_pkg::MODE_PHP: begin
                side.write_value  = (mode == c6502_pkg::MODE_PHA) ? arch_cur.acc
                                  : (arch_cur.flags | c6502_pkg::PUSH_BITS);
                side.write_enable = 1'b1;
                side.uses_stack   = 1'b1;
                arch_new.sp       = arch_cur.sp - 8'd1;
            end
            c6502_pkg::MODE_PLA: begin
                side.uses_stack    = 1'b1;
                side.stack_address = c6502_pkg::STACK_PAGE | {1'b0, sp_inc};
                arch_new.sp        = sp_inc;
                arch_new.acc       = operand;
                arch_new.flags     = c6502_pkg::set_nz(arch_cur.flags, operand);
            end
            c6502_pkg::MODE_PLP: begin
                side.uses_stack    = 1'b1;
                side.stack_address = c6502_pkg::STACK_PAGE | {1'b0, sp_inc};
                arch_new.sp        = sp_inc;
                arch_new.flags     = (operand & ~c6502_pkg::PUSH_BITS)
                                   | (arch_cur.flags & c6502_pkg::PUSH_BITS);
            end
            default: begin
                // unused codes leave every register as it is
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/cpu6502_load_shift_stack_execute.sv
// Top level of the 6502 load/shift/stack execute unit.
// Depends on c6502_pkg and c6502_alu.
//
//  channel | direction | words                                   | handshake
//  s_      | in        | mode, operand                           | s_valid / s_ready
//  m_      | out       | write/stack side outputs, A X Y P S     | m_valid / m_ready
//
// One word per cycle sustained while m_ready holds high; each word passes the
// input register, then executes into the result register. Registers update as an
// operation leaves the input register, so each word sees all earlier ones.
// Synchronous active-low reset: A, X, Y = 0, S = 0xFD, P = 0x24, both stages empty.
// A stall on m_ready holds the result register; the input register still takes
// one word, then s_ready drops until the result moves.
`default_nettype none

module cpu6502_load_shift_stack_execute (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [3:0] s_mode,
    input  wire logic [7:0] s_operand,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_write_value,
    output logic            m_write_enable,
    output logic [8:0]      m_stack_address,
    output logic            m_uses_stack,
    output logic [7:0]      m_acc_out,
    output logic [7:0]      m_x_out,
    output logic [7:0]      m_y_out,
    output logic [7:0]      m_flags_out,
    output logic [7:0]      m_stack_pointer_out
);

    logic             in_valid_reg;
    logic [3:0]       mode_reg;
    logic [7:0]       operand_reg;
    logic             out_valid_reg;
    c6502_pkg::arch_t arch_reg;
    c6502_pkg::arch_t arch_next;
    c6502_pkg::side_t side_next;
    c6502_pkg::side_t side_reg;
    c6502_pkg::arch_t view_reg;
    logic             advance;
    logic             execute;

    // Pipeline control
    assign advance = !out_valid_reg || m_ready;
    assign execute = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            mode_reg    <= s_mode;
            operand_reg <= s_operand;
        end
    end

    c6502_alu u_alu (
        .mode     (mode_reg),
        .operand  (operand_reg),
        .arch_cur (arch_reg),
        .arch_new (arch_next),
        .side     (side_next)
    );

    // Architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_reg.acc   <= 8'h00;
            arch_reg.idx_x <= 8'h00;
            arch_reg.idx_y <= 8'h00;
            arch_reg.sp    <= c6502_pkg::SP_RESET;
            arch_reg.flags <= c6502_pkg::FLAGS_RESET;
        end else if (execute) begin
            arch_reg <= arch_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (execute) begin
            side_reg <= side_next;
            view_reg <= arch_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_write_value       = side_reg.write_value;
    assign m_write_enable      = side_reg.write_enable;
    assign m_stack_address     = side_reg.stack_address;
    assign m_uses_stack        = side_reg.uses_stack;
    assign m_acc_out           = view_reg.acc;
    assign m_x_out             = view_reg.idx_x;
    assign m_y_out             = view_reg.idx_y;
    assign m_flags_out         = view_reg.flags;
    assign m_stack_pointer_out = view_reg.sp;

endmodule

`default_nettype wire

// File: hdl/c6502_checker.sv
// Port-level checks for the 6502 execute unit, bound to the top level.
// Depends on cpu6502_load_shift_stack_execute_defines.svh.
`default_nettype none
`include "cpu6502_load_shift_stack_execute_defines.svh"

module c6502_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_write_value,
    input wire logic       m_write_enable,
    input wire logic [8:0] m_stack_address,
    input wire logic [7:0] m_acc_out,
    input wire logic [7:0] m_flags_out
);

    // Bits 5 and 4 of P never move from their reset value
    `C6502_ASSERT_NOW(a_flag_fixed_bits, aclk, aresetn, m_valid, m_flags_out[5] && !m_flags_out[4])

    // No write strobe means a zero data word
    `C6502_ASSERT_NOW(a_idle_write_zero, aclk, aresetn, m_valid && !m_write_enable, m_write_value == 8'h00)

    // Stack address always lands in page one
    `C6502_ASSERT_NOW(a_stack_page_one, aclk, aresetn, m_valid, m_stack_address[8])

    // A stalled result holds
    `C6502_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_acc_out) && $stable(m_flags_out))

endmodule

bind cpu6502_load_shift_stack_execute c6502_checker u_c6502_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_write_value   (m_write_value),
    .m_write_enable  (m_write_enable),
    .m_stack_address (m_stack_address),
    .m_acc_out       (m_acc_out),
    .m_flags_out     (m_flags_out)
);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the 6502 load/shift/stack execute unit.
// Uses c6502_pkg for operation codes and constants; drives cpu6502_load_shift_stack_execute.
// A behavioral copy of A, X, Y, S and P predicts every result word; a monitor compares them.
module tb_top;
    import c6502_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_WORDS  = 290;

    // Mode codes the block must treat as no-ops
    localparam logic [3:0] MODE_SPARE_14 = 4'd14;
    localparam logic [3:0] MODE_SPARE_15 = 4'd15;
    localparam logic [7:0] ZERO_BIT      = 8'h02;

    typedef struct packed {
        logic [7:0] write_value;
        logic       write_enable;
        logic [8:0] stack_address;
        logic       uses_stack;
        logic [7:0] acc;
        logic [7:0] idx_x;
        logic [7:0] idx_y;
        logic [7:0] flags;
        logic [7:0] sp;
    } exec_result_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [3:0] s_mode    = '0;
    logic [7:0] s_operand = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_write_value;
    logic       m_write_enable;
    logic [8:0] m_stack_address;
    logic       m_uses_stack;
    logic [7:0] m_acc_out;
    logic [7:0] m_x_out;
    logic [7:0] m_y_out;
    logic [7:0] m_flags_out;
    logic [7:0] m_stack_pointer_out;

    // Architectural state as the block should hold it after each accepted word
    logic [7:0] reg_a = 8'h00;
    logic [7:0] reg_x = 8'h00;
    logic [7:0] reg_y = 8'h00;
    logic [7:0] reg_s = SP_RESET;
    logic [7:0] reg_p = FLAGS_RESET;

    exec_result_t pending_results[$];
    int           error_count        = 0;
    int           sender_idle_pct    = 0;
    int           receiver_stall_pct = 0;
    int           cycle_count        = 0;

    cpu6502_load_shift_stack_execute dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_operand           (s_operand),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_write_value       (m_write_value),
        .m_write_enable      (m_write_enable),
        .m_stack_address     (m_stack_address),
        .m_uses_stack        (m_uses_stack),
        .m_acc_out           (m_acc_out),
        .m_x_out             (m_x_out),
        .m_y_out             (m_y_out),
        .m_flags_out         (m_flags_out),
        .m_stack_pointer_out (m_stack_pointer_out)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // N and Z follow the result byte
    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] f;
        f = p & ~(SIGN_BIT | ZERO_BIT);
        if (v == 8'h00) f = f | ZERO_BIT;
        f = f | (v & SIGN_BIT);
        return f;
    endfunction

    // LSR / ROL / ROR through carry; updates reg_p
    function automatic logic [7:0] shift_byte(input logic [3:0] mode, input logic [7:0] v);
        logic       cin;
        logic       cout;
        logic [7:0] r;
        cin = reg_p[0];
        case (mode)
            MODE_LSR_A, MODE_LSR_M: begin
                cout = v[0];
                r    = {1'b0, v[7:1]};
            end
            MODE_ROL_A, MODE_ROL_M: begin
                cout = v[7];
                r    = {v[6:0], cin};
            end
            default: begin
                cout = v[0];
                r    = {cin, v[7:1]};
            end
        endcase
        reg_p = (reg_p & ~CARRY_BIT) | (cout ? CARRY_BIT : 8'h00);
        reg_p = with_nz(reg_p, r);
        return r;
    endfunction

    // Executes one word against the shadow registers and returns the expected result
    function automatic exec_result_t execute_word(input logic [3:0] mode,
                                                  input logic [7:0] operand);
        exec_result_t r;
        r.write_value   = 8'h00;
        r.write_enable  = 1'b0;
        r.stack_address = STACK_PAGE | {1'b0, reg_s};
        r.uses_stack    = 1'b0;
        case (mode)
            MODE_LDA: begin
                reg_a = operand;
                reg_p = with_nz(reg_p, operand);
            end
            MODE_LDX: begin
                reg_x = operand;
                reg_p = with_nz(reg_p, operand);
            end
            MODE_LDY: begin
                reg_y = operand;
                reg_p = with_nz(reg_p, operand);
            end
            MODE_ORA: begin
                reg_a = reg_a | operand;
                reg_p = with_nz(reg_p, reg_a);
            end
            MODE_LSR_A, MODE_ROL_A, MODE_ROR_A: begin
                reg_a = shift_byte(mode, reg_a);
            end
            MODE_LSR_M, MODE_ROL_M, MODE_ROR_M: begin
                r.write_value  = shift_byte(mode, operand);
                r.write_enable = 1'b1;
            end
            MODE_PHA, MODE_PHP: begin
                // push goes to the current S, then S decrements
                r.write_value  = (mode == MODE_PHA) ? reg_a : (reg_p | PUSH_BITS);
                r.write_enable = 1'b1;
                r.uses_stack   = 1'b1;
                reg_s          = reg_s - 8'd1;
            end
            MODE_PLA, MODE_PLP: begin
                // pull increments S first
                reg_s           = reg_s + 8'd1;
                r.stack_address = STACK_PAGE | {1'b0, reg_s};
                r.uses_stack    = 1'b1;
                if (mode == MODE_PLA) begin
                    reg_a = operand;
                    reg_p = with_nz(reg_p, operand);
                end else begin
                    // bits 5 and 4 are not stored by PLP
                    reg_p = (operand & ~PUSH_BITS) | (reg_p & PUSH_BITS);
                end
            end
            default: ;
        endcase
        r.acc   = reg_a;
        r.idx_x = reg_x;
        r.idx_y = reg_y;
        r.flags = reg_p;
        r.sp    = reg_s;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [8:0] want,
                                        input logic [8:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    // Result monitor
    always @(posedge aclk) begin
        exec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word arrived with no expectation pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("write_value", 9'(want.write_value), 9'(m_write_value));
                check_field("write_enable", 9'(want.write_enable), 9'(m_write_enable));
                check_field("stack_address", want.stack_address, m_stack_address);
                check_field("uses_stack", 9'(want.uses_stack), 9'(m_uses_stack));
                check_field("acc_out", 9'(want.acc), 9'(m_acc_out));
                check_field("x_out", 9'(want.idx_x), 9'(m_x_out));
                check_field("y_out", 9'(want.idx_y), 9'(m_y_out));
                check_field("flags_out", 9'(want.flags), 9'(m_flags_out));
                check_field("stack_pointer_out", 9'(want.sp), 9'(m_stack_pointer_out));
            end
        end
    end

    // Sends one word, with random idle cycles ahead of it; valid stays up after acceptance
    task automatic send_word(input logic [3:0] mode, input logic [7:0] operand);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_operand <= operand;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(execute_word(mode, operand));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // A no-op first shows the reset register values
    task automatic test_reset_view();
        send_word(MODE_SPARE_14, 8'hFF);
    endtask

    task automatic test_loads();
        send_word(MODE_LDA, 8'h00);
        send_word(MODE_LDA, 8'h80);
        send_word(MODE_LDX, 8'hFF);
        send_word(MODE_LDX, 8'h00);
        send_word(MODE_LDY, 8'h7F);
        send_word(MODE_LDY, 8'h80);
        send_word(MODE_LDA, 8'h41);
    endtask

    // ORA, then carry chains through consecutive shifts and rotates
    task automatic test_ora_and_shifts();
        send_word(MODE_ORA, 8'h0F);
        send_word(MODE_LSR_A, 8'h00);
        send_word(MODE_LSR_M, 8'h01);
        send_word(MODE_ROL_A, 8'hFF);
        send_word(MODE_ROL_M, 8'h80);
        send_word(MODE_ROR_A, 8'h00);
        send_word(MODE_ROR_M, 8'h01);
    endtask

    task automatic test_stack_ops();
        send_word(MODE_PHA, 8'h00);
        send_word(MODE_PHP, 8'h00);
        send_word(MODE_PLA, 8'h00);
        send_word(MODE_PLP, 8'hFF);
        send_word(MODE_PLP, 8'h00);
    endtask

    // S walks up through 0xFF to 0x00 and back down
    task automatic test_stack_wrap();
        send_word(MODE_PLA, 8'h42);
        send_word(MODE_PLA, 8'h00);
        send_word(MODE_PHA, 8'h00);
        send_word(MODE_PHP, 8'h00);
    endtask

    task automatic test_unused_modes();
        send_word(MODE_SPARE_15, 8'h55);
    endtask

    // Random words under a given idle / stall mix
    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        logic [7:0] operand;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0: operand = 8'h00;
                1: operand = 8'hFF;
                2: operand = SIGN_BIT;
                3: operand = CARRY_BIT;
                default: operand = 8'($urandom_range(0, 255));
            endcase
            send_word(4'($urandom_range(0, 15)), operand);
        end
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_view();
        test_loads();
        test_ora_and_shifts();
        test_stack_ops();
        test_stack_wrap();
        test_unused_modes();
        drain_results();

        test_random_traffic(PHASE_WORDS, 0, 0);
        test_random_traffic(PHASE_WORDS, 67, 0);
        test_random_traffic(PHASE_WORDS, 0, 67);
        test_random_traffic(PHASE_WORDS, 15, 15);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
